/* rtl/mau_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_pkg
// Shared types and constants of the modular arithmetic unit.
// ----------------------------------------------------------------------------
package mau_pkg;

    localparam int unsigned EXP_BITS_DEF = 64;
    localparam int unsigned MOD_BITS_DEF = 32;
    localparam int unsigned QUEUE_DEPTH  = 2;

    localparam logic [31:0] MODULUS_RESET = 32'd998244353;
    localparam logic [31:0] MODULUS_MIN   = 32'd2;
    localparam logic [31:0] MODULUS_MAX   = 32'h8000_0000;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_POW = 3'd4,
        OP_INV = 3'd5,
        OP_NEG = 3'd6,
        OP_RED = 3'd7
    } t_op;

    // wide holds the exponent for power, or the magnitude of the signed value
    typedef struct packed {
        t_op         op;
        logic [30:0] a;
        logic [30:0] b;
        logic [63:0] wide;
        logic        neg;
    } t_item;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
        logic [6:0]  steps;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
        logic [31:0] remainder;
    } t_div_rsp;

endpackage

/* rtl/mau_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_front
// Input stage: takes a beat, decodes the action and prepares the wide operand.
// ----------------------------------------------------------------------------
module mau_front import mau_pkg::*; #(
    parameter int unsigned EXPONENT_BITS = EXP_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [2:0]               i_action,
    input  logic [30:0]              i_operand_a,
    input  logic [30:0]              i_operand_b,
    input  logic [EXPONENT_BITS-1:0] i_exponent,
    input  logic signed [63:0]       i_signed_value,
    output logic                     o_q_valid,
    output t_item                    o_q_item,
    input  logic                     i_q_ready
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  accept;

    assign o_stall   = r_valid && !i_q_ready;
    assign accept    = i_valid && !o_stall;
    assign o_q_valid = r_valid;
    assign o_q_item  = r_item;

    always_comb begin
        n_item.a    = i_operand_a;
        n_item.b    = i_operand_b;
        n_item.neg  = 1'b0;
        n_item.wide = 64'(i_exponent);
        case (i_action)
            OP_ADD:  n_item.op = OP_ADD;
            OP_SUB:  n_item.op = OP_SUB;
            OP_MUL:  n_item.op = OP_MUL;
            OP_DIV:  n_item.op = OP_DIV;
            OP_POW:  n_item.op = OP_POW;
            OP_INV:  n_item.op = OP_INV;
            OP_NEG:  n_item.op = OP_NEG;
            default: n_item.op = OP_RED;
        endcase
        if (n_item.op == OP_RED) begin
            n_item.neg  = i_signed_value[63];
            // -2^63 wraps to 2^63, which is the right magnitude unsigned
            n_item.wide = i_signed_value[63] ? (64'd0 - i_signed_value) : i_signed_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
                r_item  <= n_item;
            end else if (i_q_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

/* rtl/mau_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_fifo
// Short queue of decoded items between the front and the back end.
// ----------------------------------------------------------------------------
module mau_fifo import mau_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* rtl/mau_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_div
// Restoring divider, one quotient bit per cycle, dividend taken MSB first.
// ----------------------------------------------------------------------------
module mau_div import mau_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [6:0]  r_cnt;
    logic [63:0] r_dvd;
    logic [63:0] r_quo;
    logic [31:0] r_rem;
    logic [31:0] r_dsr;
    logic [32:0] trial;
    logic        ge;

    assign trial = {r_rem, r_dvd[63]};
    assign ge    = (trial >= {1'b0, r_dsr});

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
                r_dvd  <= i_req.dividend;
                r_dsr  <= i_req.divisor;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[62:0], 1'b0};
                r_quo <= {r_quo[62:0], ge};
                // partial remainder stays below the divisor, so 32 bits hold it
                r_rem <= ge ? 32'(trial - {1'b0, r_dsr}) : trial[31:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/mau_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mau_back
// Execution sequencer: operand reduction, add, sub, negate, multiply-reduce,
// square-and-multiply, extended Euclid and signed reduction on one shared divider.
// ----------------------------------------------------------------------------
module mau_back import mau_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_mod,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [30:0] o_result,
    output logic        o_not_invertible
);

    typedef enum logic [4:0] {
        S_IDLE, S_RA_GO, S_RA_WAIT, S_RB_GO, S_RB_WAIT, S_DISPATCH,
        S_MUL, S_MD_GO, S_MD_WAIT, S_POW,
        S_EU_TEST, S_EU_WAIT, S_EU_MUL, S_EU_UPD, S_EU_FIN,
        S_RED_GO, S_RED_WAIT, S_DONE
    } t_state;

    t_state             r_state;
    t_op                r_op;
    logic [63:0]        r_wide;
    logic               r_neg;
    logic [30:0]        r_ra;
    logic [30:0]        r_rb;
    logic [30:0]        r_x;
    logic [30:0]        r_y;
    logic [61:0]        r_prod;
    logic [30:0]        r_acc;
    logic [30:0]        r_base;
    logic [63:0]        r_exp;
    logic               r_sq;
    logic [31:0]        r_s;
    logic [31:0]        r_t;
    logic signed [32:0] r_ca;
    logic signed [32:0] r_cb;
    logic [31:0]        r_q;
    logic [31:0]        r_r;
    logic signed [33:0] r_cprod;
    logic               r_bad;
    logic [30:0]        r_res;
    logic               r_out_valid;
    logic [30:0]        r_out_res;
    logic               r_out_bad;

    t_div_req           div_req;
    t_div_rsp           div_rsp;
    logic [31:0]        sum;
    logic [31:0]        diff;
    logic [31:0]        neg_a;
    logic [31:0]        red_res;
    logic signed [33:0] mod_s;
    logic signed [33:0] fix;
    logic signed [33:0] inv_val;

    mau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_q_pop          = (r_state == S_IDLE) && i_q_valid;
    assign o_valid          = r_out_valid;
    assign o_result         = r_out_res;
    assign o_not_invertible = r_out_bad;

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = {1'b0, r_ra, 32'h0};
        div_req.divisor  = i_mod;
        div_req.steps    = 7'd32;
        case (r_state)
            S_RA_GO: begin
                div_req.start = 1'b1;
            end
            S_RB_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {1'b0, r_rb, 32'h0};
            end
            S_MD_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {2'b00, r_prod};
                div_req.steps    = 7'd64;
            end
            S_EU_TEST: begin
                div_req.start    = (r_t != '0);
                div_req.dividend = {r_s, 32'h0};
                div_req.divisor  = r_t;
            end
            S_RED_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_wide;
                div_req.steps    = 7'd64;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_comb begin
        sum     = {1'b0, r_ra} + {1'b0, r_rb};
        if (sum >= i_mod) begin
            sum = sum - i_mod;
        end
        diff    = (r_ra >= r_rb) ? {1'b0, r_ra} - {1'b0, r_rb}
                                 : {1'b0, r_ra} + i_mod - {1'b0, r_rb};
        neg_a   = (r_ra == '0) ? '0 : i_mod - {1'b0, r_ra};
        red_res = (r_neg && div_rsp.remainder != '0) ? i_mod - div_rsp.remainder
                                                     : div_rsp.remainder;
        mod_s   = $signed({2'b00, i_mod});
        // Euclid coefficient brought into [0, modulus)
        fix     = (r_ca < 0) ? 34'(r_ca) + mod_s : 34'(r_ca);
        inv_val = (fix >= mod_s) ? fix - mod_s : fix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_op    <= i_q_item.op;
                        r_ra    <= i_q_item.a;
                        r_rb    <= i_q_item.b;
                        r_wide  <= i_q_item.wide;
                        r_neg   <= i_q_item.neg;
                        r_bad   <= 1'b0;
                        r_state <= S_RA_GO;
                    end
                end
                S_RA_GO: r_state <= S_RA_WAIT;
                S_RA_WAIT: begin
                    if (div_rsp.done) begin
                        r_ra    <= div_rsp.remainder[30:0];
                        r_state <= S_RB_GO;
                    end
                end
                S_RB_GO: r_state <= S_RB_WAIT;
                S_RB_WAIT: begin
                    if (div_rsp.done) begin
                        r_rb    <= div_rsp.remainder[30:0];
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    case (r_op)
                        OP_ADD: begin
                            r_res   <= sum[30:0];
                            r_state <= S_DONE;
                        end
                        OP_SUB: begin
                            r_res   <= diff[30:0];
                            r_state <= S_DONE;
                        end
                        OP_NEG: begin
                            r_res   <= neg_a[30:0];
                            r_state <= S_DONE;
                        end
                        OP_MUL: begin
                            r_x     <= r_ra;
                            r_y     <= r_rb;
                            r_state <= S_MUL;
                        end
                        OP_DIV, OP_INV: begin
                            r_s     <= i_mod;
                            r_t     <= {1'b0, (r_op == OP_DIV) ? r_rb : r_ra};
                            r_ca    <= '0;
                            r_cb    <= 33'sd1;
                            r_state <= S_EU_TEST;
                        end
                        OP_POW: begin
                            r_acc   <= 31'd1;
                            r_base  <= r_ra;
                            r_exp   <= r_wide;
                            r_state <= S_POW;
                        end
                        default: begin
                            r_state <= S_RED_GO;
                        end
                    endcase
                end
                S_MUL: begin
                    r_prod  <= r_x * r_y;
                    r_state <= S_MD_GO;
                end
                S_MD_GO: r_state <= S_MD_WAIT;
                S_MD_WAIT: begin
                    if (div_rsp.done) begin
                        if (r_op == OP_POW) begin
                            if (!r_sq) begin
                                r_acc   <= div_rsp.remainder[30:0];
                                r_x     <= r_base;
                                r_y     <= r_base;
                                r_sq    <= 1'b1;
                                r_state <= S_MUL;
                            end else begin
                                r_base  <= div_rsp.remainder[30:0];
                                r_exp   <= {1'b0, r_exp[63:1]};
                                r_state <= S_POW;
                            end
                        end else begin
                            r_res   <= div_rsp.remainder[30:0];
                            r_state <= S_DONE;
                        end
                    end
                end
                S_POW: begin
                    if (r_exp == '0) begin
                        r_res   <= r_acc;
                        r_state <= S_DONE;
                    end else begin
                        r_x     <= r_exp[0] ? r_acc : r_base;
                        r_y     <= r_base;
                        r_sq    <= !r_exp[0];
                        r_state <= S_MUL;
                    end
                end
                S_EU_TEST: begin
                    if (r_t == '0) begin
                        r_bad   <= (r_s != 32'd1);
                        r_state <= S_EU_FIN;
                    end else begin
                        r_state <= S_EU_WAIT;
                    end
                end
                S_EU_WAIT: begin
                    if (div_rsp.done) begin
                        r_q     <= div_rsp.quotient[31:0];
                        r_r     <= div_rsp.remainder;
                        r_state <= S_EU_MUL;
                    end
                end
                S_EU_MUL: begin
                    // coefficients stay within twice the modulus
                    r_cprod <= 34'(r_cb * $signed({1'b0, r_q}));
                    r_state <= S_EU_UPD;
                end
                S_EU_UPD: begin
                    r_ca    <= r_cb;
                    r_cb    <= 33'(34'(r_ca) - r_cprod);
                    r_s     <= r_t;
                    r_t     <= r_r;
                    r_state <= S_EU_TEST;
                end
                S_EU_FIN: begin
                    if (r_op == OP_INV) begin
                        r_res   <= inv_val[30:0];
                        r_state <= S_DONE;
                    end else begin
                        r_x     <= r_ra;
                        r_y     <= inv_val[30:0];
                        r_state <= S_MUL;
                    end
                end
                S_RED_GO: r_state <= S_RED_WAIT;
                S_RED_WAIT: begin
                    if (div_rsp.done) begin
                        r_res   <= red_res[30:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_res   <= r_res;
                        r_out_bad   <= r_bad;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/modular_arithmetic_unit_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_arithmetic_unit_top
// Modular ALU: add, sub, mul, div, pow, inverse, negate, signed reduce.
// ----------------------------------------------------------------------------
// One result beat per input beat, in order. A two-entry queue sits between
// the input stage and the execution sequencer, so up to five beats can be in
// flight. Operand reduction, multiply-reduce and signed reduction all go
// through one restoring divider at one bit per cycle. Both operands are
// reduced first and add/sub/negate finish right after; mul adds one modular
// multiply; signed reduce adds one more division; inverse costs one division
// per Euclid step; div is inverse plus one mul; pow costs up to two modular
// multiplies per exponent bit, stopping after the highest set bit. The
// modulus register is masked to MODULUS_BITS and clamped to [2, 2^31]; write
// it only while the block is idle.
module modular_arithmetic_unit_top import mau_pkg::*; #(
    parameter int unsigned EXPONENT_BITS = EXP_BITS_DEF,
    parameter int unsigned MODULUS_BITS  = MOD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [2:0]               i_action,
    input  logic [30:0]              i_operand_a,
    input  logic [30:0]              i_operand_b,
    input  logic [EXPONENT_BITS-1:0] i_exponent,
    input  logic signed [63:0]       i_signed_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [30:0]              o_result,
    output logic                     o_not_invertible,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [31:0]              i_cfg_data
);

    logic [MODULUS_BITS-1:0] r_modulus;
    logic [31:0]             mod_raw;
    logic [31:0]             mod_eff;
    logic                    q_push;
    t_item                   q_in;
    logic                    q_ready;
    logic                    q_valid;
    t_item                   q_out;
    logic                    q_pop;

    assign o_cfg_ready = 1'b1;
    assign mod_raw     = 32'(r_modulus);
    assign mod_eff     = (mod_raw < MODULUS_MIN) ? MODULUS_MIN :
                         (mod_raw > MODULUS_MAX) ? MODULUS_MAX : mod_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MODULUS_RESET[MODULUS_BITS-1:0];
        end else if (i_cfg_valid) begin
            r_modulus <= i_cfg_data[MODULUS_BITS-1:0];
        end
    end

    mau_front #(
        .EXPONENT_BITS (EXPONENT_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_exponent     (i_exponent),
        .i_signed_value (i_signed_value),
        .o_q_valid      (q_push),
        .o_q_item       (q_in),
        .i_q_ready      (q_ready)
    );

    mau_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_out),
        .i_pop   (q_pop)
    );

    mau_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_mod            (mod_eff),
        .i_q_valid        (q_valid),
        .i_q_item         (q_out),
        .o_q_pop          (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result         (o_result),
        .o_not_invertible (o_not_invertible)
    );

endmodule
